FILE: rtl/core/wfd_pkg.sv
`default_nettype none
package wfd_pkg;

	localparam int MAX_PARTICIPANTS = 8;
	localparam int IDX_W = $clog2(MAX_PARTICIPANTS);
	localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);
	localparam int CLOSE_PASSES = $clog2(MAX_PARTICIPANTS);
	localparam int PASS_W = $clog2(CLOSE_PASSES + 1);

	localparam int ID_W = 8;
	localparam int SLOT_W = 3;
	localparam int GB_W = 8;
	localparam int MEMBER_W = 8;
	localparam int CMD_W = 2;
	localparam int RS_W = 2;
	localparam int TYPE_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;

	localparam logic [RS_W-1:0] RS_STOPPED = 2'd1;
	localparam logic [RS_W-1:0] RS_WAITING = 2'd2;

	localparam logic [TYPE_W-1:0] DL_NONE = 2'd0;
	localparam logic [TYPE_W-1:0] DL_CYCLE = 2'd1;
	localparam logic [TYPE_W-1:0] DL_STOPPED = 2'd2;

	typedef logic [ID_W-1:0] id_t;
	typedef logic [GB_W-1:0] gbits_t;
	typedef logic [MAX_PARTICIPANTS-1:0] lset_t;

	typedef struct packed {
		logic clear;
		logic load;
	} tbl_ctrl_t;

	typedef struct packed {
		logic init;
		logic step;
		logic [IDX_W-1:0] row;
	} clo_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/wfd_table.sv
`default_nettype none
module wfd_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wfd_pkg::tbl_ctrl_t            ctrl,
	input  wire logic                          auto_dispatch,
	input  wire logic [wfd_pkg::ID_W-1:0]      train_number,
	input  wire logic [wfd_pkg::SLOT_W-1:0]    bit_slot,
	input  wire logic [wfd_pkg::RS_W-1:0]      run_state,
	input  wire logic [wfd_pkg::GB_W-1:0]      blocking_trains,
	input  wire logic                          has_resume_target,
	input  wire logic                          has_yield_target,
	input  wire logic                          parked_at_siding,
	output wfd_pkg::id_t                       ids [wfd_pkg::MAX_PARTICIPANTS],
	output wfd_pkg::gbits_t                    gbits [wfd_pkg::MAX_PARTICIPANTS],
	output wfd_pkg::gbits_t                    blockers [wfd_pkg::MAX_PARTICIPANTS],
	output wfd_pkg::lset_t                     waiting_set,
	output wfd_pkg::lset_t                     stopped_set,
	output logic [wfd_pkg::CNT_W-1:0]          count
);

	wfd_pkg::id_t                 ids_q [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::gbits_t              gbits_q [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::gbits_t              blk_q [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::lset_t               waiting_q;
	wfd_pkg::lset_t               stopped_q;
	logic [wfd_pkg::CNT_W-1:0]    count_q;
	logic                         is_waiting;
	logic                         is_stopped;
	logic                         keep;
	logic                         do_write;
	logic [wfd_pkg::IDX_W-1:0]    wr_idx;

	assign is_waiting = (run_state == wfd_pkg::RS_WAITING);
	assign is_stopped = (run_state == wfd_pkg::RS_STOPPED);
	assign keep = is_waiting || (is_stopped && !auto_dispatch) ||
		(is_stopped && has_resume_target && has_yield_target && parked_at_siding);
	assign do_write = ctrl.load && keep &&
		(count_q < wfd_pkg::CNT_W'(wfd_pkg::MAX_PARTICIPANTS));
	assign wr_idx = count_q[wfd_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			waiting_q <= '0;
			stopped_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
			waiting_q <= '0;
			stopped_q <= '0;
		end else if (do_write) begin
			count_q <= count_q + wfd_pkg::CNT_W'(1);
			if (is_waiting) begin
				waiting_q[wr_idx] <= 1'b1;
			end else begin
				stopped_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write && !ctrl.clear) begin
			ids_q[wr_idx] <= train_number;
			gbits_q[wr_idx] <= wfd_pkg::GB_W'(1) << bit_slot;
			blk_q[wr_idx] <= blocking_trains;
		end
	end

	assign ids = ids_q;
	assign gbits = gbits_q;
	assign blockers = blk_q;
	assign waiting_set = waiting_q;
	assign stopped_set = stopped_q;
	assign count = count_q;

endmodule
`default_nettype wire

FILE: rtl/core/wfd_closure.sv
`default_nettype none
module wfd_closure (
	input  wire logic                  clk,
	input  wire wfd_pkg::clo_ctrl_t    ctrl,
	input  wire logic [wfd_pkg::CNT_W-1:0] count,
	input  wire wfd_pkg::lset_t        waiting_set,
	input  wire wfd_pkg::gbits_t       gbits [wfd_pkg::MAX_PARTICIPANTS],
	input  wire wfd_pkg::gbits_t       blockers [wfd_pkg::MAX_PARTICIPANTS],
	output wfd_pkg::lset_t             reach [wfd_pkg::MAX_PARTICIPANTS]
);

	wfd_pkg::lset_t reach_q [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::lset_t init_row [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::lset_t live;
	wfd_pkg::lset_t row_cur;
	wfd_pkg::lset_t row_new;

	// A row is live when its participant is loaded and waiting.
	always_comb begin
		for (int i = 0; i < wfd_pkg::MAX_PARTICIPANTS; i++) begin
			live[i] = waiting_set[i] && (wfd_pkg::CNT_W'(i) < count);
		end
		for (int i = 0; i < wfd_pkg::MAX_PARTICIPANTS; i++) begin
			init_row[i] = '0;
			if (live[i]) begin
				for (int j = 0; j < wfd_pkg::MAX_PARTICIPANTS; j++) begin
					init_row[i][j] = (i == j) ||
						(live[j] && ((blockers[i] & gbits[j]) != '0));
				end
			end
		end
	end

	// The shared row unit: one row absorbs every row it already reaches.
	always_comb begin
		row_cur = reach_q[ctrl.row];
		row_new = row_cur;
		for (int j = 0; j < wfd_pkg::MAX_PARTICIPANTS; j++) begin
			if (row_cur[j]) begin
				row_new = row_new | reach_q[j];
			end
		end
		row_new = row_new & waiting_set;
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			reach_q <= init_row;
		end else if (ctrl.step) begin
			reach_q[ctrl.row] <= row_new;
		end
	end

	assign reach = reach_q;

endmodule
`default_nettype wire

FILE: rtl/core/wait_for_deadlock_detector.sv
// Wait-for deadlock detector. Each input word is a command: clear empties the
// participant table, and load adds one agent view if the agent is waiting or
// a stopped agent the table keeps, and the table is not full. A detect finds
// the queried agent, builds the wait-for graph among the waiting participants
// and closes it with one shared row unit that updates one reachability row per
// cycle, three passes over all eight rows. A detect for a waiting participant
// runs through the init, close and evaluate states to the output state, and
// the input is ready again in the same cycle as its result is presented; one
// for an unknown or non-waiting agent goes from find to output. Only detect
// produces a result word. The input is not ready while a detect runs, and a
// result word that has not been taken yet holds the next detect in its output
// state. Write the configuration register only while no word is in flight.
`default_nettype none
module wait_for_deadlock_detector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [wfd_pkg::CMD_W-1:0]     cmd,
	input  wire logic [wfd_pkg::ID_W-1:0]      train_number,
	input  wire logic [wfd_pkg::SLOT_W-1:0]    bit_slot,
	input  wire logic [wfd_pkg::RS_W-1:0]      run_state,
	input  wire logic [wfd_pkg::GB_W-1:0]      blocking_trains,
	input  wire logic                          has_resume_target,
	input  wire logic                          has_yield_target,
	input  wire logic                          parked_at_siding,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          auto_dispatch,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [wfd_pkg::TYPE_W-1:0]         deadlock_type,
	output logic [wfd_pkg::MEMBER_W-1:0]       member_set,
	output logic [wfd_pkg::GB_W-1:0]           member_global_bits,
	output logic                               victim_valid,
	output logic [wfd_pkg::ID_W-1:0]           victim_train
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_INIT,
		S_CLOSE,
		S_EVAL,
		S_OUT
	} state_t;

	state_t                         state_q;
	logic                           auto_q;
	wfd_pkg::id_t                   qid_q;
	logic [wfd_pkg::IDX_W-1:0]      start_q;
	logic [wfd_pkg::IDX_W-1:0]      row_q;
	logic [wfd_pkg::PASS_W-1:0]     pass_q;
	logic [wfd_pkg::TYPE_W-1:0]     type_q;
	wfd_pkg::lset_t                 members_q;
	logic [wfd_pkg::IDX_W-1:0]      vic_q;
	logic                           vic_ok_q;
	logic                           out_valid_q;
	logic [wfd_pkg::TYPE_W-1:0]     out_type_q;
	logic [wfd_pkg::MEMBER_W-1:0]   out_members_q;
	logic [wfd_pkg::GB_W-1:0]       out_gbits_q;
	logic                           out_vic_ok_q;
	logic [wfd_pkg::ID_W-1:0]       out_vic_q;

	wfd_pkg::tbl_ctrl_t             tbl_ctrl;
	wfd_pkg::clo_ctrl_t             clo_ctrl;
	wfd_pkg::id_t                   ids [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::gbits_t                gbits [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::gbits_t                blockers [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::lset_t                 reach [wfd_pkg::MAX_PARTICIPANTS];
	wfd_pkg::lset_t                 waiting_set;
	wfd_pkg::lset_t                 stopped_set;
	logic [wfd_pkg::CNT_W-1:0]      count;

	logic                           in_acc;
	wfd_pkg::lset_t                 match;
	wfd_pkg::lset_t                 sbit;
	wfd_pkg::lset_t                 cyc;
	wfd_pkg::lset_t                 bl;
	wfd_pkg::gbits_t                gsum;
	logic                           out_free;

	function automatic logic [wfd_pkg::IDX_W-1:0] first_set(input wfd_pkg::lset_t m);
		logic [wfd_pkg::IDX_W-1:0] r;
		r = '0;
		for (int i = wfd_pkg::MAX_PARTICIPANTS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = wfd_pkg::IDX_W'(i);
			end
		end
		return r;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign tbl_ctrl.clear = in_acc && (cmd == wfd_pkg::CMD_CLEAR);
	assign tbl_ctrl.load = in_acc && (cmd == wfd_pkg::CMD_LOAD);
	assign clo_ctrl.init = (state_q == S_INIT);
	assign clo_ctrl.step = (state_q == S_CLOSE);
	assign clo_ctrl.row = row_q;

	wfd_table u_table (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (tbl_ctrl),
		.auto_dispatch     (auto_q),
		.train_number      (train_number),
		.bit_slot          (bit_slot),
		.run_state         (run_state),
		.blocking_trains   (blocking_trains),
		.has_resume_target (has_resume_target),
		.has_yield_target  (has_yield_target),
		.parked_at_siding  (parked_at_siding),
		.ids               (ids),
		.gbits             (gbits),
		.blockers          (blockers),
		.waiting_set       (waiting_set),
		.stopped_set       (stopped_set),
		.count             (count)
	);

	wfd_closure u_closure (
		.clk         (clk),
		.ctrl        (clo_ctrl),
		.count       (count),
		.waiting_set (waiting_set),
		.gbits       (gbits),
		.blockers    (blockers),
		.reach       (reach)
	);

	always_comb begin
		sbit = wfd_pkg::MAX_PARTICIPANTS'(1) << start_q;
		for (int i = 0; i < wfd_pkg::MAX_PARTICIPANTS; i++) begin
			match[i] = (wfd_pkg::CNT_W'(i) < count) && (ids[i] == qid_q);
			cyc[i] = waiting_set[i] && reach[start_q][i] && reach[i][start_q];
			bl[i] = stopped_set[i] && ((blockers[start_q] & gbits[i]) != '0);
		end
		gsum = '0;
		for (int i = 0; i < wfd_pkg::MAX_PARTICIPANTS; i++) begin
			if (members_q[i]) begin
				gsum = gsum | gbits[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			auto_q <= auto_dispatch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			row_q <= '0;
			pass_q <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (cmd == wfd_pkg::CMD_DETECT)) begin
						qid_q <= train_number;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					start_q <= first_set(match);
					type_q <= wfd_pkg::DL_NONE;
					members_q <= '0;
					vic_ok_q <= 1'b0;
					vic_q <= '0;
					if ((match != '0) && waiting_set[first_set(match)]) begin
						state_q <= S_INIT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_INIT: begin
					row_q <= '0;
					pass_q <= '0;
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (row_q == wfd_pkg::IDX_W'(wfd_pkg::MAX_PARTICIPANTS - 1)) begin
						row_q <= '0;
						pass_q <= pass_q + wfd_pkg::PASS_W'(1);
						if (pass_q == wfd_pkg::PASS_W'(wfd_pkg::CLOSE_PASSES - 1)) begin
							state_q <= S_EVAL;
						end
					end else begin
						row_q <= row_q + wfd_pkg::IDX_W'(1);
					end
				end
				S_EVAL: begin
					// The queried agent always reaches itself, so a cycle needs one more.
					if ((cyc & ~sbit) != '0) begin
						type_q <= wfd_pkg::DL_CYCLE;
						members_q <= cyc;
						vic_q <= first_set(cyc);
						vic_ok_q <= 1'b1;
					end else if (bl != '0) begin
						type_q <= wfd_pkg::DL_STOPPED;
						members_q <= bl | sbit;
						vic_q <= first_set(bl);
						vic_ok_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_type_q <= type_q;
						out_members_q <= wfd_pkg::MEMBER_W'(members_q);
						out_gbits_q <= gsum;
						out_vic_ok_q <= vic_ok_q;
						out_vic_q <= vic_ok_q ? ids[vic_q] : '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign deadlock_type = out_type_q;
	assign member_set = out_members_q;
	assign member_global_bits = out_gbits_q;
	assign victim_valid = out_vic_ok_q;
	assign victim_train = out_vic_q;

	a_found_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (deadlock_type != wfd_pkg::DL_NONE)
		|-> victim_valid && ($countones(member_set) >= 2))
		else $error("reported deadlock lacks a victim or has too few members");

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (deadlock_type == wfd_pkg::DL_NONE)
		|-> (member_set == '0) && (member_global_bits == '0) && !victim_valid
		&& (victim_train == '0))
		else $error("empty result carries members or a victim");

	a_detect_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == wfd_pkg::CMD_DETECT) |=> state_q == S_FIND)
		else $error("accepted detect did not start the search");

	a_closure_before_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(state_q) == S_CLOSE)
		else $error("evaluation entered without finishing the closure");

endmodule
`default_nettype wire
